@@ rtl/core/itcm_pkg.sv @@
package itcm_pkg;

    // Frame store and timer sizing
    localparam int BUFFER_SIZE    = 64;
    localparam int MAX_CMD_LEN    = 7;
    localparam int NUM_COMMANDS   = 5;
    localparam int TIMER_W        = 16;

    localparam int COUNT_W        = $clog2(BUFFER_SIZE);
    localparam int BYTE_IDX_W     = (MAX_CMD_LEN > 1) ? $clog2(MAX_CMD_LEN) : 1;
    localparam int STORE_LIMIT    = BUFFER_SIZE - 1;

    // Field and register widths
    localparam int BYTE_W         = 8;
    localparam int IDLE_LIMIT_W   = 16;
    localparam int CMD_COUNT_W    = 3;
    localparam int CMD_WORD_W     = 59;
    localparam int CMD_LEN_LSB    = 56;
    localparam int CMD_LEN_W      = 3;
    localparam int CMD_IDX_W      = 3;
    localparam int FRAME_LEN_W    = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int OUT_TDATA_W    = 16;

    // Queue between frame collector and matcher
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

    // Reset values of the configuration registers
    localparam logic [IDLE_LIMIT_W-1:0] IDLE_LIMIT_RST = IDLE_LIMIT_W'(170);
    localparam logic [CMD_COUNT_W-1:0]  CMD_COUNT_RST  = CMD_COUNT_W'(5);
    localparam logic [CMD_WORD_W-1:0]   CMD_WORD_0_RST = 59'd288230376980376931;
    localparam logic [CMD_WORD_W-1:0]   CMD_WORD_1_RST = 59'd288230376997154147;
    localparam logic [CMD_WORD_W-1:0]   CMD_WORD_2_RST = 59'd288230377013931363;
    localparam logic [CMD_WORD_W-1:0]   CMD_WORD_3_RST = 59'd288230378037863784;
    localparam logic [CMD_WORD_W-1:0]   CMD_WORD_4_RST = 59'd288230377296841817;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IDLE_LIMIT    = 3'd0,
        REG_COMMAND_COUNT = 3'd1,
        REG_COMMAND_WORD0 = 3'd2,
        REG_COMMAND_WORD1 = 3'd3,
        REG_COMMAND_WORD2 = 3'd4,
        REG_COMMAND_WORD3 = 3'd5,
        REG_COMMAND_WORD4 = 3'd6
    } t_reg_idx;

    // Input item kinds (carried on tuser)
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef logic [NUM_COMMANDS-1:0][CMD_WORD_W-1:0] t_cmd_words;

    // One ended frame as handed from collector to matcher
    typedef struct packed {
        logic [MAX_CMD_LEN-1:0][BYTE_W-1:0] bytes;
        logic [COUNT_W-1:0]                 count;
    } t_frame_rec;

    // Queue status seen by collector and matcher
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

@@ rtl/core/itcm_front.sv @@
module itcm_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_fire,
    input  logic                                  i_mode,
    input  logic [itcm_pkg::BYTE_W-1:0]           i_rx_byte,
    input  logic [itcm_pkg::IDLE_LIMIT_W-1:0]     i_idle_limit,
    output logic                                  o_push,
    output itcm_pkg::t_frame_rec                  o_rec
);

    logic [itcm_pkg::MAX_CMD_LEN-1:0][itcm_pkg::BYTE_W-1:0] r_bytes, n_bytes;
    logic [itcm_pkg::COUNT_W-1:0]  r_count, n_count;
    logic                          r_pending, n_pending;
    logic [itcm_pkg::TIMER_W-1:0]  r_timer, n_timer;
    logic [itcm_pkg::TIMER_W-1:0]  timer_inc;
    logic                          frame_end;

    assign timer_inc = (r_timer == '1) ? r_timer : r_timer + 1'b1;
    assign frame_end = i_fire && (i_mode == itcm_pkg::MODE_TICK) && r_pending &&
                       (32'(timer_inc) > 32'(i_idle_limit));

    always_comb begin
        n_bytes   = r_bytes;
        n_count   = r_count;
        n_pending = r_pending;
        n_timer   = r_timer;
        if (i_fire) begin
            if (i_mode == itcm_pkg::MODE_BYTE) begin
                if (r_count < itcm_pkg::COUNT_W'(itcm_pkg::STORE_LIMIT)) begin
                    if (r_count < itcm_pkg::COUNT_W'(itcm_pkg::MAX_CMD_LEN)) begin
                        n_bytes[r_count[itcm_pkg::BYTE_IDX_W-1:0]] = i_rx_byte;
                    end
                    n_count   = r_count + 1'b1;
                    n_pending = 1'b1;
                    n_timer   = '0;
                end
            end else begin
                n_timer = timer_inc;
                // timer keeps running across the frame end
                if (frame_end) begin
                    n_bytes   = '0;
                    n_count   = '0;
                    n_pending = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes   <= '0;
            r_count   <= '0;
            r_pending <= 1'b0;
            r_timer   <= '0;
        end else begin
            r_bytes   <= n_bytes;
            r_count   <= n_count;
            r_pending <= n_pending;
            r_timer   <= n_timer;
        end
    end

    assign o_push      = frame_end;
    assign o_rec.bytes = r_bytes;
    assign o_rec.count = r_count;

`ifndef NO_ASSERTIONS
    a_pending_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == (r_count != '0))
        else $error("pending flag out of step with byte count");
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= itcm_pkg::COUNT_W'(itcm_pkg::STORE_LIMIT))
        else $error("byte count past store limit");
`endif

endmodule

@@ rtl/core/itcm_queue.sv @@
module itcm_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  itcm_pkg::t_frame_rec    i_rec,
    input  logic                    i_pop,
    output itcm_pkg::t_frame_rec    o_rec,
    output itcm_pkg::t_queue_status o_status
);

    itcm_pkg::t_frame_rec r_mem [itcm_pkg::QUEUE_DEPTH];
    logic [itcm_pkg::QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [itcm_pkg::QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [itcm_pkg::QUEUE_CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == itcm_pkg::QUEUE_PTR_W'(itcm_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == itcm_pkg::QUEUE_PTR_W'(itcm_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    assign o_rec          = r_mem[r_rd_ptr];
    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == itcm_pkg::QUEUE_CNT_W'(itcm_pkg::QUEUE_DEPTH));

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("frame pushed into full queue");
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("frame popped from empty queue");
`endif

endmodule

@@ rtl/core/itcm_back.sv @@
module itcm_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  itcm_pkg::t_frame_rec                  i_rec,
    input  itcm_pkg::t_queue_status               i_status,
    output logic                                  o_pop,
    input  logic [itcm_pkg::CMD_COUNT_W-1:0]      i_cmd_count,
    input  itcm_pkg::t_cmd_words                  i_cmd_words,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_matched,
    output logic [itcm_pkg::CMD_IDX_W-1:0]        o_cmd_index,
    output logic [itcm_pkg::FRAME_LEN_W-1:0]      o_frame_length
);

    logic [itcm_pkg::NUM_COMMANDS-1:0] cmd_hit;
    logic                              hit;
    logic [itcm_pkg::CMD_IDX_W-1:0]    hit_index;
    logic                              load;

    logic                               r_valid, n_valid;
    logic                               r_matched;
    logic [itcm_pkg::CMD_IDX_W-1:0]     r_index;
    logic [itcm_pkg::FRAME_LEN_W-1:0]   r_length;

    // Compare the head frame against every table entry in parallel
    always_comb begin
        logic [itcm_pkg::CMD_LEN_W-1:0] len;
        logic                           eq;
        for (int i = 0; i < itcm_pkg::NUM_COMMANDS; i++) begin
            len = i_cmd_words[i][itcm_pkg::CMD_LEN_LSB +: itcm_pkg::CMD_LEN_W];
            eq  = 1'b1;
            for (int k = 0; k < itcm_pkg::MAX_CMD_LEN; k++) begin
                if (k < int'(len) &&
                    i_rec.bytes[k] != i_cmd_words[i][k*itcm_pkg::BYTE_W +: itcm_pkg::BYTE_W]) begin
                    eq = 1'b0;
                end
            end
            cmd_hit[i] = (i < int'(i_cmd_count)) && (len != '0) &&
                         (int'(len) <= itcm_pkg::MAX_CMD_LEN) &&
                         (int'(len) == int'(i_rec.count)) && eq;
        end
    end

    // Lowest matching index wins
    always_comb begin
        hit       = 1'b0;
        hit_index = '0;
        for (int i = itcm_pkg::NUM_COMMANDS - 1; i >= 0; i--) begin
            if (cmd_hit[i]) begin
                hit       = 1'b1;
                hit_index = itcm_pkg::CMD_IDX_W'(i);
            end
        end
    end

    assign load = !i_status.empty && (!r_valid || i_ready);

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_matched <= hit;
            r_index   <= hit_index;
            r_length  <= itcm_pkg::FRAME_LEN_W'(i_rec.count);
        end
    end

    assign o_pop          = load;
    assign o_valid        = r_valid;
    assign o_matched      = r_matched;
    assign o_cmd_index    = r_index;
    assign o_frame_length = r_length;

`ifndef NO_ASSERTIONS
    a_index_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_matched) |-> (r_index == '0))
        else $error("nonzero command index without a match");
    a_length_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_length != '0))
        else $error("ended frame reported with no bytes");
`endif

endmodule

@@ rtl/core/idle_timeout_command_matcher.sv @@
// Idle-timeout command matcher. Each input beat is either a received byte
// (tuser = 0) or a one-microsecond tick (tuser = 1). Bytes collect into a
// frame (up to BUFFER_SIZE-1 counted, the first seven kept for comparison)
// and each stored byte restarts a saturating 16-bit idle timer; a byte that
// arrives with the store full is dropped. A tick that takes the timer past
// idle_limit while a frame is held ends the frame: the frame is compared with
// the first command_count table entries and one output beat carries the match
// flag, the lowest matching index (zero on a miss) and the frame length. The
// input side takes one beat per clock while s_axis_tready is high. An ended
// frame passes through a two-entry queue and then the output register before
// its result beat is offered. s_axis_tready falls only while both queue
// entries hold frames whose results the downstream has not yet taken.
// Configuration writes are always taken (o_cfg_ready stays high) and must be
// issued only while the block has no frame in flight.
module idle_timeout_command_matcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
    input  logic                                s_axis_tuser,  // [0] mode
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] matched, [3:1] command_index, [9:4] frame_length, [15:10] zero
    output logic [itcm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [itcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [itcm_pkg::CMD_WORD_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [itcm_pkg::IDLE_LIMIT_W-1:0] r_idle_limit;
    logic [itcm_pkg::CMD_COUNT_W-1:0]  r_cmd_count;
    itcm_pkg::t_cmd_words              r_cmd_words;

    logic                    in_fire;
    logic                    push;
    logic                    pop;
    itcm_pkg::t_frame_rec    front_rec;
    itcm_pkg::t_frame_rec    head_rec;
    itcm_pkg::t_queue_status q_status;

    logic                                matched;
    logic [itcm_pkg::CMD_IDX_W-1:0]      cmd_index;
    logic [itcm_pkg::FRAME_LEN_W-1:0]    frame_length;

    assign o_cfg_ready = 1'b1;

    // Register writes; index past the table is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit   <= itcm_pkg::IDLE_LIMIT_RST;
            r_cmd_count    <= itcm_pkg::CMD_COUNT_RST;
            r_cmd_words[0] <= itcm_pkg::CMD_WORD_0_RST;
            r_cmd_words[1] <= itcm_pkg::CMD_WORD_1_RST;
            r_cmd_words[2] <= itcm_pkg::CMD_WORD_2_RST;
            r_cmd_words[3] <= itcm_pkg::CMD_WORD_3_RST;
            r_cmd_words[4] <= itcm_pkg::CMD_WORD_4_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                itcm_pkg::REG_IDLE_LIMIT: begin
                    r_idle_limit <= i_cfg_data[itcm_pkg::IDLE_LIMIT_W-1:0];
                end
                itcm_pkg::REG_COMMAND_COUNT: begin
                    r_cmd_count <= i_cfg_data[itcm_pkg::CMD_COUNT_W-1:0];
                end
                itcm_pkg::REG_COMMAND_WORD0: r_cmd_words[0] <= i_cfg_data;
                itcm_pkg::REG_COMMAND_WORD1: r_cmd_words[1] <= i_cfg_data;
                itcm_pkg::REG_COMMAND_WORD2: r_cmd_words[2] <= i_cfg_data;
                itcm_pkg::REG_COMMAND_WORD3: r_cmd_words[3] <= i_cfg_data;
                itcm_pkg::REG_COMMAND_WORD4: r_cmd_words[4] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Hold off input only when an ended frame would find no queue slot
    assign s_axis_tready = !q_status.full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    itcm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_mode       (s_axis_tuser),
        .i_rx_byte    (s_axis_tdata),
        .i_idle_limit (r_idle_limit),
        .o_push       (push),
        .o_rec        (front_rec)
    );

    itcm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (front_rec),
        .i_pop    (pop),
        .o_rec    (head_rec),
        .o_status (q_status)
    );

    itcm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec          (head_rec),
        .i_status       (q_status),
        .o_pop          (pop),
        .i_cmd_count    (r_cmd_count),
        .i_cmd_words    (r_cmd_words),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_matched      (matched),
        .o_cmd_index    (cmd_index),
        .o_frame_length (frame_length)
    );

    // Pack the result beat, lowest field first
    assign m_axis_tdata = {
        (itcm_pkg::OUT_TDATA_W - 1 - itcm_pkg::CMD_IDX_W - itcm_pkg::FRAME_LEN_W)'(0),
        frame_length,
        cmd_index,
        matched
    };

endmodule

@@ dv/idle_timeout_command_matcher_tb.sv @@
module idle_timeout_command_matcher_tb;

    import itcm_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;

    // One input beat: tuser carries the mode, tdata the received byte
    typedef struct {
        logic       mode;
        logic [7:0] rx_byte;
    } t_rx_beat;

    // Verdict for one ended frame
    typedef struct {
        logic                   matched;
        logic [CMD_IDX_W-1:0]   cmd_idx;
        logic [FRAME_LEN_W-1:0] frame_len;
    } t_frame_verdict;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;    // [7:0] rx_byte
    logic                   s_axis_tuser = 1'b0;  // [0] mode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] matched, [3:1] command_index, [9:4] frame_length, [15:10] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CMD_WORD_W-1:0]  i_cfg_data = '0;

    // Beats waiting for the driver, and verdicts waiting for the result port
    t_rx_beat       pending_beats[$];
    t_frame_verdict expected_verdicts[$];
    int             beats_queued = 0;
    int             beats_taken = 0;
    int             fail_count = 0;
    int             cycle_count = 0;

    // Idle pattern state for each side
    int             snd_gap = 0;
    int             snd_left = 0;
    bit             snd_calm = 1'b0;
    int             rcv_stall = 0;
    int             rcv_left = 0;
    bit             rcv_calm = 1'b0;

    // Predicted frame collector state and configuration copy
    logic [7:0]             mdl_bytes [MAX_CMD_LEN];
    int                     mdl_count = 0;
    bit                     mdl_pending = 1'b0;
    logic [TIMER_W-1:0]     mdl_timer = '0;
    logic [IDLE_LIMIT_W-1:0] cfg_idle_limit;
    logic [CMD_COUNT_W-1:0] cfg_cmd_count;
    logic [CMD_WORD_W-1:0]  cfg_cmd_words [NUM_COMMANDS];

    idle_timeout_command_matcher u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Wait length for the next beat; stretches of zero waits and stretches of
    // random waits follow one another in random order
    function automatic int next_wait(inout int left, inout bit calm);
        if (left == 0) begin
            left = $urandom_range(8, 48);
            calm = ($urandom_range(0, 3) == 0);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic void note_fail(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    // Advance the predicted collector by one accepted beat; a tick that ends
    // a frame queues its verdict
    function automatic void absorb_beat(input logic mode, input logic [7:0] rx);
        t_frame_verdict v;
        int             used;
        int             len;
        bit             same;
        if (mode == MODE_BYTE) begin
            // drop the byte once the store is full; the timer keeps running
            if (mdl_count < STORE_LIMIT) begin
                if (mdl_count < MAX_CMD_LEN) mdl_bytes[mdl_count] = rx;
                mdl_count++;
                mdl_pending = 1'b1;
                mdl_timer = '0;
            end
            return;
        end
        // tick: advance the saturating timer first, then test for frame end
        if (mdl_timer != '1) mdl_timer++;
        if (!mdl_pending || mdl_timer <= cfg_idle_limit) return;
        v.matched = 1'b0;
        v.cmd_idx = '0;
        v.frame_len = FRAME_LEN_W'(mdl_count);
        used = (cfg_cmd_count > NUM_COMMANDS) ? NUM_COMMANDS : cfg_cmd_count;
        for (int c = 0; c < used && !v.matched; c++) begin
            len = cfg_cmd_words[c][CMD_LEN_LSB +: CMD_LEN_W];
            same = (len != 0) && (len == mdl_count);
            for (int k = 0; k < len && same; k++)
                same = (mdl_bytes[k] == cfg_cmd_words[c][8*k +: 8]);
            if (same) begin
                v.matched = 1'b1;
                v.cmd_idx = CMD_IDX_W'(c);
            end
        end
        expected_verdicts.push_back(v);
        foreach (mdl_bytes[k]) mdl_bytes[k] = '0;
        mdl_count = 0;
        mdl_pending = 1'b0;
    endfunction

    // Input driver: present queued beats, predict each one as it is taken
    always @(posedge i_clk) begin : drive_beats
        t_rx_beat b;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            snd_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_beat(s_axis_tuser, s_axis_tdata);
                beats_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (snd_gap != 0) begin
                    snd_gap <= snd_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    b = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= b.mode;
                    s_axis_tdata <= b.rx_byte;
                    snd_gap <= next_wait(snd_left, snd_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each taken beat with the oldest verdict, then
    // draw a random wait and hold the port's tready low while it lasts
    always @(posedge i_clk) begin : watch_results
        t_frame_verdict v;
        int             w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rcv_stall <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                note_fail($sformatf("unexpected result beat tdata=%h", m_axis_tdata));
            end else begin
                v = expected_verdicts.pop_front();
                if (m_axis_tdata[0] !== v.matched || m_axis_tdata[3:1] !== v.cmd_idx ||
                    m_axis_tdata[9:4] !== v.frame_len || m_axis_tdata[15:10] !== '0)
                    note_fail($sformatf({"result mismatch: expected matched=%0b index=%0d ",
                        "length=%0d, got matched=%0b index=%0d length=%0d fill=%h"},
                        v.matched, v.cmd_idx, v.frame_len, m_axis_tdata[0],
                        m_axis_tdata[3:1], m_axis_tdata[9:4], m_axis_tdata[15:10]));
            end
            w = next_wait(rcv_left, rcv_calm);
            if (w != 0) begin
                m_axis_tready <= 1'b0;
                rcv_stall <= w - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end else if (rcv_stall != 0) begin
            rcv_stall <= rcv_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        t_rx_beat e;
        e.mode = MODE_BYTE;
        e.rx_byte = b;
        pending_beats.push_back(e);
        beats_queued++;
    endtask

    // Ticks carry a random byte that the block must ignore
    task automatic push_ticks(input int n);
        t_rx_beat e;
        repeat (n) begin
            e.mode = MODE_TICK;
            e.rx_byte = 8'($urandom);
            pending_beats.push_back(e);
            beats_queued++;
        end
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) push_byte(s[k]);
    endtask

    // Write one register; the copy used for prediction follows at the handshake.
    // The caller lowers i_cfg_valid after the last write of a batch.
    task automatic write_reg(input t_reg_idx idx, input logic [CMD_WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_IDLE_LIMIT:    cfg_idle_limit = data[IDLE_LIMIT_W-1:0];
            REG_COMMAND_COUNT: cfg_cmd_count = data[CMD_COUNT_W-1:0];
            default:           cfg_cmd_words[idx - REG_COMMAND_WORD0] = data;
        endcase
    endtask

    // Hold until every queued beat is taken and every verdict has arrived,
    // then let the output pipeline settle
    task automatic drain();
        while (beats_taken != beats_queued || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [CMD_WORD_W-1:0] rand_word();
        return CMD_WORD_W'({$urandom, $urandom});
    endfunction

    initial begin : run_phases
        logic [IDLE_LIMIT_W-1:0] lim;
        logic [CMD_WORD_W-1:0]   w;
        logic [7:0]              frm[$];
        int                      sel;
        int                      c;
        int                      len;
        int                      nt;
        int                      pos;
        int                      made;

        cfg_idle_limit = IDLE_LIMIT_RST;
        cfg_cmd_count = CMD_COUNT_RST;
        cfg_cmd_words[0] = CMD_WORD_0_RST;
        cfg_cmd_words[1] = CMD_WORD_1_RST;
        cfg_cmd_words[2] = CMD_WORD_2_RST;
        cfg_cmd_words[3] = CMD_WORD_3_RST;
        cfg_cmd_words[4] = CMD_WORD_4_RST;
        foreach (mdl_bytes[k]) mdl_bytes[k] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset table: a frame equal to the last entry, and a short prefix
        // of the first one that matches nothing
        push_text("YLAD");
        push_ticks(int'(IDLE_LIMIT_RST) + 1);
        push_text("cmd");
        push_ticks(int'(IDLE_LIMIT_RST) + 1);
        drain();

        // Directed table: one-byte zero, all-ones seven-byte, zero length,
        // and a duplicated "abc" so the lower index must win
        w = rand_word();
        w[IDLE_LIMIT_W-1:0] = 16'd2;
        write_reg(REG_IDLE_LIMIT, w);
        w = rand_word();
        w[CMD_COUNT_W-1:0] = 3'd7;     // above the table size, clamps to five
        write_reg(REG_COMMAND_COUNT, w);
        w = rand_word();
        w[CMD_LEN_LSB +: CMD_LEN_W] = 3'd1;
        w[7:0] = 8'h00;
        write_reg(REG_COMMAND_WORD0, w);
        write_reg(REG_COMMAND_WORD1, '1);
        write_reg(REG_COMMAND_WORD2, '0);
        w = rand_word();
        w[CMD_LEN_LSB +: CMD_LEN_W] = 3'd3;
        w[23:0] = 24'h636261;
        write_reg(REG_COMMAND_WORD3, w);
        w = rand_word();
        w[CMD_LEN_LSB +: CMD_LEN_W] = 3'd3;
        w[23:0] = 24'h636261;
        write_reg(REG_COMMAND_WORD4, w);
        i_cfg_valid <= 1'b0;

        push_byte(8'h00);
        push_ticks(3);
        repeat (7) push_byte(8'hFF);
        push_ticks(3);
        push_text("xbc");              // differs in the first byte only
        push_ticks(3);
        push_text("abc");
        push_ticks(3);
        push_ticks(2);                 // nothing held: no result
        repeat (8) push_byte(8'hFF);   // longer than any command
        push_ticks(3);
        push_text("ab");
        push_ticks(2);                 // timer equal to the limit: frame stays open
        push_text("c");
        push_ticks(3);
        drain();

        // Empty table, then a full store; the dropped byte must not restart
        // the timer, so one tick after it ends the frame
        w = rand_word();
        w[CMD_COUNT_W-1:0] = 3'd0;
        write_reg(REG_COMMAND_COUNT, w);
        i_cfg_valid <= 1'b0;
        repeat (BUFFER_SIZE) push_byte(8'($urandom));
        push_ticks(2);
        push_byte(8'($urandom));
        push_ticks(1);
        push_byte(8'h00);
        push_ticks(3);
        drain();

        // Top limit: ticks leave the frame open; a lower limit written while
        // the frame is held lets the next tick end it
        w = rand_word();
        w[IDLE_LIMIT_W-1:0] = '1;
        write_reg(REG_IDLE_LIMIT, w);
        w = rand_word();
        w[CMD_COUNT_W-1:0] = 3'd5;
        write_reg(REG_COMMAND_COUNT, w);
        i_cfg_valid <= 1'b0;
        push_text("a");
        push_ticks(40);
        drain();
        w = rand_word();
        w[IDLE_LIMIT_W-1:0] = 16'd30;
        write_reg(REG_IDLE_LIMIT, w);
        i_cfg_valid <= 1'b0;
        push_ticks(1);

        // Random phases: new table each time, mostly frames built from the
        // table with some corrupted, plus long frames and loose noise
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            lim = (ph == 0) ? 16'd1 : (ph == 7) ? 16'd12 : 16'($urandom_range(1, 6));
            w = rand_word();
            w[IDLE_LIMIT_W-1:0] = lim;
            write_reg(REG_IDLE_LIMIT, w);
            w = rand_word();
            w[CMD_COUNT_W-1:0] = (ph == 1) ? 3'd0 : (ph == 2) ? 3'd7 :
                                 CMD_COUNT_W'($urandom_range(3, 5));
            write_reg(REG_COMMAND_COUNT, w);
            for (int i = 0; i < NUM_COMMANDS; i++) begin
                w = rand_word();
                w[CMD_LEN_LSB +: CMD_LEN_W] = ($urandom_range(0, 7) == 0) ? 3'd0 :
                                              CMD_LEN_W'($urandom_range(1, 7));
                if (i != 0 && $urandom_range(0, 3) == 0) w = cfg_cmd_words[i-1];
                write_reg(t_reg_idx'(REG_COMMAND_WORD0 + i), w);
            end
            i_cfg_valid <= 1'b0;

            made = 0;
            while (made < 150) begin
                sel = $urandom_range(0, 99);
                if (sel < 65) begin
                    c = $urandom_range(0, NUM_COMMANDS - 1);
                    len = cfg_cmd_words[c][CMD_LEN_LSB +: CMD_LEN_W];
                    frm.delete();
                    for (int k = 0; k < len; k++) frm.push_back(cfg_cmd_words[c][8*k +: 8]);
                    if (len != 0 && $urandom_range(0, 3) == 0) begin
                        pos = $urandom_range(0, len - 1);
                        frm[pos] = frm[pos] ^ 8'(1 << $urandom_range(0, 7));
                    end
                    if ($urandom_range(0, 7) == 0) frm.push_back(8'($urandom));
                    else if (len > 1 && $urandom_range(0, 7) == 0) void'(frm.pop_back());
                    foreach (frm[k]) push_byte(frm[k]);
                    // now and then stop short so the frame runs on into the next
                    nt = ($urandom_range(0, 6) == 0) ? $urandom_range(0, lim) :
                         lim + 1 + $urandom_range(0, 2);
                    push_ticks(nt);
                    made += frm.size() + nt;
                end else if (sel < 78) begin
                    len = $urandom_range(8, 70);
                    repeat (len) push_byte(8'($urandom));
                    push_ticks(lim + 1);
                    made += len + lim + 1;
                end else begin
                    len = $urandom_range(1, 8);
                    repeat (len) begin
                        if ($urandom_range(0, 1) == 0) push_ticks(1);
                        else push_byte(8'($urandom));
                    end
                    made += len;
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ idle_timeout_command_matcher.f @@
rtl/core/itcm_pkg.sv
rtl/core/itcm_front.sv
rtl/core/itcm_queue.sv
rtl/core/itcm_back.sv
rtl/core/idle_timeout_command_matcher.sv
dv/idle_timeout_command_matcher_tb.sv
